### hw/rtl/lshi_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the lattice site halo index block.
package lshi_pkg;

  localparam int NUM_DIMS   = 4;
  localparam int COORD_W    = 10;
  localparam int IDX_W      = 33;
  localparam int OFS_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // modulo unit: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = COORD_W / DIV_STEPS;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SIZES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_SIZES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_VOLUME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_VOLUME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSETS_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSETS_HIGH  = 3'd6;

  typedef logic [1:0] dim_t;

  // halo base info handed from selection to index arithmetic
  typedef struct packed {
    logic             found;
    logic             fwd;
    logic [IDX_W-1:0] base;
  } lshi_sel_t;

  // width of a wrapped coordinate: wrapped value or unwrapped signed input
  function automatic int coord_xw(input int size_bits);
    return (size_bits + 1 > COORD_W) ? size_bits + 1 : COORD_W;
  endfunction

  // k-th of the three dimensions other than d, ascending
  function automatic dim_t other_dim(input dim_t d, input dim_t k);
    return (k < d) ? k : dim_t'(k + 2'd1);
  endfunction

endpackage

### hw/rtl/lattice_site_halo_index.sv
`timescale 1ns / 1ps
// Lattice site halo index: 4D coordinate to local or halo site index, top level.
//
// Maps a 4D coordinate, possibly one step outside the local box, to a local
// or halo site index. The block is fully pipelined: it takes one coordinate
// per clock while the output side does not stall. The pipeline holds the
// periodic wrap, a modulo unit of five stages resolving two quotient bits
// each plus sign and fixup stages, two classification/selection stages, and
// three multiply-add stages followed by the output register. A stall on the
// output holds each stage; empty stages keep filling. Configuration is to be
// written through the plain write port only while no coordinate is in flight;
// the block itself does not enforce this.
module lattice_site_halo_index import lshi_pkg::*; #(
  parameter int SIZE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // input coordinates
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,   // coord_dim0, coord_dim1, coord_dim2, coord_dim3
  // results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // site_index, zero fill
  output logic                  m_tuser,   // found
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW = coord_xw(SIZE_BITS);

  logic [31:0]         local_sizes;
  logic [31:0]         global_sizes;
  logic [NUM_DIMS-1:0] parallel_mask;
  logic [31:0]         local_volume;
  logic [31:0]         border_volume;
  logic [63:0]         border_offsets_low;
  logic [63:0]         border_offsets_high;

  logic [NUM_DIMS-1:0][SIZE_BITS-1:0] lsize, gsize;
  logic [NUM_DIMS-1:0][OFS_W-1:0]     offs;
  logic [63:0]                        lsize_ext, gsize_ext;

  logic                               w_valid, w_ready;
  logic [NUM_DIMS-1:0][XW-1:0]        w_x;
  logic                               c_valid, c_ready;
  logic [NUM_DIMS-1:0][XW-1:0]        c_a;
  logic [NUM_DIMS-1:1][SIZE_BITS-1:0] c_s;
  lshi_sel_t                          c_sel;
  logic [IDX_W-1:0]                   site_index;
  logic                               found;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_sizes         <= 32'h0101_0101;
      global_sizes        <= 32'h0101_0101;
      parallel_mask       <= '0;
      local_volume        <= 32'd1;
      border_volume       <= '0;
      border_offsets_low  <= '0;
      border_offsets_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_SIZES:   local_sizes         <= cfg_data[31:0];
        CFG_GLOBAL_SIZES:  global_sizes        <= cfg_data[31:0];
        CFG_PARALLEL_MASK: parallel_mask       <= cfg_data[NUM_DIMS-1:0];
        CFG_LOCAL_VOLUME:  local_volume        <= cfg_data[31:0];
        CFG_BORDER_VOLUME: border_volume       <= cfg_data[31:0];
        CFG_OFFSETS_LOW:   border_offsets_low  <= cfg_data;
        CFG_OFFSETS_HIGH:  border_offsets_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack extents, dimension 0 in the most significant field
  assign lsize_ext = {32'd0, local_sizes};
  assign gsize_ext = {32'd0, global_sizes};

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      lsize[d] = lsize_ext[(NUM_DIMS-1-d)*SIZE_BITS +: SIZE_BITS];
      gsize[d] = gsize_ext[(NUM_DIMS-1-d)*SIZE_BITS +: SIZE_BITS];
    end
  end

  assign offs[0] = border_offsets_low[31:0];
  assign offs[1] = border_offsets_low[63:32];
  assign offs[2] = border_offsets_high[31:0];
  assign offs[3] = border_offsets_high[63:32];

  lshi_wrap #(.SIZE_BITS(SIZE_BITS)) u_wrap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_coord  (s_tdata[NUM_DIMS*COORD_W-1:0]),
    .gsize     (gsize),
    .out_valid (w_valid),
    .out_ready (w_ready),
    .out_x     (w_x)
  );

  lshi_select #(.SIZE_BITS(SIZE_BITS)) u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (w_valid),
    .in_ready  (w_ready),
    .in_x      (w_x),
    .lsize     (lsize),
    .gsize     (gsize),
    .pmask     (parallel_mask),
    .lvol      (local_volume),
    .offs      (offs),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_a     (c_a),
    .out_s     (c_s),
    .out_sel   (c_sel)
  );

  lshi_index #(.SIZE_BITS(SIZE_BITS)) u_index (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_a      (c_a),
    .in_s      (c_s),
    .in_sel    (c_sel),
    .half_vol  (border_volume >> 1),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (site_index),
    .out_found (found)
  );

  assign m_tdata = {7'd0, site_index};
  assign m_tuser = found;

`ifndef SYNTHESIS
  // a miss always carries a zero index
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("not-found result with nonzero index");

  // pipeline is empty right after reset
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // a taking sink never back-pressures the input
  assert property (@(posedge clk) m_tready |-> s_tready)
    else $error("input stalled while output is being taken");

  // input only stalls behind a waiting result
  assert property (@(posedge clk) !s_tready |-> m_tvalid)
    else $error("input stalled with empty output register");
`endif

endmodule

### hw/rtl/lshi_wrap.sv
`timescale 1ns / 1ps
// Pipelined periodic wrap of the four coordinates into their global sizes.
module lshi_wrap import lshi_pkg::*; #(
  parameter int SIZE_BITS = 8,
  localparam int XW = coord_xw(SIZE_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [NUM_DIMS-1:0][COORD_W-1:0]   in_coord,
  input  logic [NUM_DIMS-1:0][SIZE_BITS-1:0] gsize,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [NUM_DIMS-1:0][XW-1:0]        out_x
);

  localparam int NST = DIV_STAGES + 2;

  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  logic [NUM_DIMS-1:0][COORD_W-1:0]   raw_q [DIV_STAGES+1];
  logic [NUM_DIMS-1:0]                neg_q [DIV_STAGES+1];
  logic [NUM_DIMS-1:0][COORD_W-1:0]   mag_q [DIV_STAGES+1];
  logic [NUM_DIMS-1:0][SIZE_BITS-1:0] rem_q [DIV_STAGES+1];
  logic [NUM_DIMS-1:0][SIZE_BITS-1:0] rem_next [DIV_STAGES];
  logic [NUM_DIMS-1:0][XW-1:0]        x_next;

  // one restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [SIZE_BITS-1:0] div_step(
    input logic [SIZE_BITS-1:0] r,
    input logic                 b,
    input logic [SIZE_BITS-1:0] g
  );
    logic [SIZE_BITS:0] t;
    t = {r, b};
    if (t >= {1'b0, g}) begin
      t = t - {1'b0, g};
    end
    return t[SIZE_BITS-1:0];
  endfunction

  // stall chain: a stage moves when it is empty or its successor moves
  always_comb begin
    adv[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // remainder steps of each division stage
  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        rem_next[s][d] = rem_q[s][d];
        for (int j = 0; j < DIV_STEPS; j++) begin
          rem_next[s][d] = div_step(rem_next[s][d], mag_q[s][d][COORD_W-1-j], gsize[d]);
        end
      end
    end
  end

  // sign fixup; a zero global size leaves the coordinate unwrapped
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (gsize[d] == '0) begin
        x_next[d] = XW'($signed(raw_q[DIV_STAGES][d]));
      end else if (neg_q[DIV_STAGES][d] && rem_q[DIV_STAGES][d] != '0) begin
        x_next[d] = XW'(gsize[d] - rem_q[DIV_STAGES][d]);
      end else begin
        x_next[d] = XW'(rem_q[DIV_STAGES][d]);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        raw_q[0][d] <= in_coord[d];
        neg_q[0][d] <= in_coord[d][COORD_W-1];
        mag_q[0][d] <= in_coord[d][COORD_W-1] ? COORD_W'(-in_coord[d]) : in_coord[d];
        rem_q[0][d] <= '0;
      end
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      if (adv[s]) begin
        raw_q[s] <= raw_q[s-1];
        neg_q[s] <= neg_q[s-1];
        rem_q[s] <= rem_next[s-1];
        for (int d = 0; d < NUM_DIMS; d++) begin
          mag_q[s][d] <= mag_q[s-1][d] << DIV_STEPS;
        end
      end
    end
    if (adv[NST-1]) begin
      out_x <= x_next;
    end
  end

endmodule

### hw/rtl/lshi_select.sv
`timescale 1ns / 1ps
// Local / face classification and selection of the index operands.
module lshi_select import lshi_pkg::*; #(
  parameter int SIZE_BITS = 8,
  localparam int XW = coord_xw(SIZE_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [NUM_DIMS-1:0][XW-1:0]        in_x,
  input  logic [NUM_DIMS-1:0][SIZE_BITS-1:0] lsize,
  input  logic [NUM_DIMS-1:0][SIZE_BITS-1:0] gsize,
  input  logic [NUM_DIMS-1:0]                pmask,
  input  logic [OFS_W-1:0]                   lvol,
  input  logic [NUM_DIMS-1:0][OFS_W-1:0]     offs,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [NUM_DIMS-1:0][XW-1:0]        out_a,
  output logic [NUM_DIMS-1:1][SIZE_BITS-1:0] out_s,
  output lshi_sel_t                          out_sel
);

  logic [1:0] vld;
  logic [1:0] adv;

  logic [NUM_DIMS-1:0][XW-1:0] x_q;
  logic                        loc_q;
  logic [NUM_DIMS-1:0]         face_q;
  logic [NUM_DIMS-1:0]         fwd_q;

  logic                        loc_next;
  logic [NUM_DIMS-1:0]         face_next;
  logic [NUM_DIMS-1:0]         fwd_next;
  logic [XW-1:0]               gm1;

  logic                               one_face;
  dim_t                               f;
  logic [NUM_DIMS-1:0][XW-1:0]        a_next;
  logic [NUM_DIMS-1:1][SIZE_BITS-1:0] s_next;
  lshi_sel_t                          sel_next;

  always_comb begin
    adv[1] = !vld[1] || out_ready;
    adv[0] = !vld[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      if (adv[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  // per-dimension inside test and face test; forward wins over backward
  always_comb begin
    loc_next = 1'b1;
    gm1      = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      gm1 = XW'(gsize[d]) - XW'(1);
      if (in_x[d][XW-1] || !(in_x[d] < XW'(lsize[d]))) begin
        loc_next = 1'b0;
      end
      fwd_next[d]  = pmask[d] && (in_x[d] == XW'(lsize[d]));
      face_next[d] = fwd_next[d] || (pmask[d] && (in_x[d] == gm1));
    end
  end

  // halo dimension, operand order and halo base
  always_comb begin
    one_face = (face_q != '0) && ((face_q & (face_q - 1'b1)) == '0);
    f = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (face_q[d]) begin
        f = dim_t'(d);
      end
    end
    a_next   = '0;
    s_next   = '0;
    sel_next = '0;
    if (loc_q) begin
      a_next         = x_q;
      s_next         = lsize[NUM_DIMS-1:1];
      sel_next.found = 1'b1;
    end else if (one_face) begin
      for (int k = 0; k < NUM_DIMS - 1; k++) begin
        a_next[k+1] = x_q[other_dim(f, dim_t'(k))];
      end
      s_next[2]      = lsize[other_dim(f, dim_t'(1))];
      s_next[3]      = lsize[other_dim(f, dim_t'(2))];
      sel_next.found = 1'b1;
      sel_next.fwd   = fwd_q[f];
      sel_next.base  = IDX_W'(lvol) + IDX_W'(offs[f]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_q    <= in_x;
      loc_q  <= loc_next;
      face_q <= face_next;
      fwd_q  <= fwd_next;
    end
    if (adv[1]) begin
      out_a   <= a_next;
      out_s   <= s_next;
      out_sel <= sel_next;
    end
  end

endmodule

### hw/rtl/lshi_index.sv
`timescale 1ns / 1ps
// Row-major index by a three-stage multiply-add chain plus halo base.
module lshi_index import lshi_pkg::*; #(
  parameter int SIZE_BITS = 8,
  localparam int XW = coord_xw(SIZE_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [NUM_DIMS-1:0][XW-1:0]        in_a,
  input  logic [NUM_DIMS-1:1][SIZE_BITS-1:0] in_s,
  input  lshi_sel_t                          in_sel,
  input  logic [OFS_W-1:0]                   half_vol,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [IDX_W-1:0]                   out_index,
  output logic                               out_found
);

  localparam int NST = 4;

  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  logic [IDX_W-1:0]     acc0, acc1, acc2;
  logic [IDX_W-1:0]     base0, base1, base2;
  logic [2:0]           found_q;
  logic [XW-1:0]        a2_q0, a3_q0, a3_q1;
  logic [SIZE_BITS-1:0] s2_q0, s3_q0, s3_q1;

  always_comb begin
    adv[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // arithmetic wraps modulo 2^IDX_W; coordinates are sign extended
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      acc0 <= IDX_W'(IDX_W'($signed(in_a[0])) * IDX_W'(in_s[1]))
              + IDX_W'($signed(in_a[1]));
      base0      <= in_sel.base + (in_sel.fwd ? IDX_W'(half_vol) : '0);
      found_q[0] <= in_sel.found;
      a2_q0      <= in_a[2];
      a3_q0      <= in_a[3];
      s2_q0      <= in_s[2];
      s3_q0      <= in_s[3];
    end
    if (adv[1]) begin
      acc1       <= IDX_W'(acc0 * IDX_W'(s2_q0)) + IDX_W'($signed(a2_q0));
      base1      <= base0;
      found_q[1] <= found_q[0];
      a3_q1      <= a3_q0;
      s3_q1      <= s3_q0;
    end
    if (adv[2]) begin
      acc2       <= IDX_W'(acc1 * IDX_W'(s3_q1)) + IDX_W'($signed(a3_q1));
      base2      <= base1;
      found_q[2] <= found_q[1];
    end
    if (adv[3]) begin
      out_index <= found_q[2] ? acc2 + base2 : '0;
      out_found <= found_q[2];
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench of lattice_site_halo_index: directed table, random phases, predicted results.
module testbench import lshi_pkg::*; ();

  localparam int SZ_W        = 8;
  localparam int NUM_REGS    = 7;
  localparam int DIR_N       = 26;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 200000;

  // one result: site index and found flag
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             found;
  } site_res_t;

  // one directed row; chk marks an expectation typed in by hand
  typedef struct packed {
    int               phase;
    int               c0;
    int               c1;
    int               c2;
    int               c3;
    logic             chk;
    logic [IDX_W-1:0] idx;
    logic             found;
  } stim_row_t;

  // full register set, indexed by the package register codes
  typedef logic [0:NUM_REGS-1][CFG_DATA_W-1:0] cfg_set_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [39:0]           s_tdata;   // coord_dim0, coord_dim1, coord_dim2, coord_dim3
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;   // site_index, zero fill
  logic                  m_tuser;   // found
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_set_t  cfg_reg;
  site_res_t pending_sites[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        rx_stall = 0;
  bit        tx_burst = 1'b0;
  bit        rx_burst = 1'b0;

  // register sets of the directed part; set 0 is the reset state
  cfg_set_t dir_cfg [0:4] = '{
    '{64'h01010101, 64'h01010101, 64'h0, 64'd1, 64'd0, 64'h0, 64'h0},
    '{64'h04030205, 64'h0806030A, 64'hF, 64'd120, 64'd308,
      64'h0000001E_00000000, 64'h00000082_00000046},
    '{64'hFFFFFFFF_FFFFFFFF, 64'h0, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF,
      64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF},
    '{64'h0, 64'h05050505, 64'h0, 64'd1, 64'd0, 64'h0, 64'h0},
    '{64'h0, 64'h05050505, 64'hF, 64'd1, 64'd10, 64'd7, 64'h0}
  };

  // phase, coordinates dim0..dim3, typed flag, index, found
  stim_row_t dir_tbl [0:DIR_N-1] = '{
    // reset sizes of 1: everything wraps onto site 0
    '{0, 0, 0, 0, 0, 1'b1, 33'd0, 1'b1},
    '{0, 511, -512, -1, 1, 1'b1, 33'd0, 1'b1},
    // box 4x3x2x5 in 8x6x3x10, all dims split
    '{1, 0, 0, 0, 0, 1'b1, 33'd0, 1'b1},
    '{1, 3, 2, 1, 4, 1'b1, 33'd119, 1'b1},
    '{1, -1, 0, 0, 0, 1'b1, 33'd120, 1'b1},
    '{1, 4, 0, 0, 0, 1'b1, 33'd274, 1'b1},
    '{1, 4, 4, 0, 0, 1'b0, 33'd0, 1'b0},
    '{1, 4, 3, 0, 0, 1'b1, 33'd0, 1'b0},
    '{1, 5, 0, 0, 0, 1'b1, 33'd0, 1'b0},
    '{1, 0, -1, 0, 0, 1'b1, 33'd150, 1'b1},
    // dim 2: backward and forward faces coincide, forward wins
    '{1, 0, 0, 2, 0, 1'b1, 33'd344, 1'b1},
    '{1, 0, 0, -1, 0, 1'b1, 33'd344, 1'b1},
    '{1, 0, 0, 0, -1, 1'b1, 33'd250, 1'b1},
    '{1, 0, 0, 0, 5, 1'b1, 33'd404, 1'b1},
    '{1, 8, 6, 3, 10, 1'b1, 33'd0, 1'b1},
    '{1, 17, -13, 9, 25, 1'b0, 33'd0, 1'b0},
    // zero global sizes, widest boxes, all-ones volumes and offsets
    '{2, -1, 0, 0, 0, 1'b0, 33'd0, 1'b0},
    '{2, 254, 254, 254, 254, 1'b0, 33'd0, 1'b0},
    '{2, 255, 0, 0, 0, 1'b0, 33'd0, 1'b0},
    '{2, 511, 511, 511, 511, 1'b1, 33'd0, 1'b0},
    '{2, -512, 0, 0, 0, 1'b1, 33'd0, 1'b0},
    // zero local sizes, no split dims
    '{3, 0, 0, 0, 0, 1'b1, 33'd0, 1'b0},
    '{3, -1, 7, 3, 4, 1'b1, 33'd0, 1'b0},
    // zero local sizes, all dims split: 0 is the forward face
    '{4, 0, 0, 0, 0, 1'b1, 33'd0, 1'b0},
    '{4, 0, 1, 1, 1, 1'b0, 33'd0, 1'b0},
    '{4, 4, 1, 1, 1, 1'b0, 33'd0, 1'b0}
  };

  lattice_site_halo_index #(
    .SIZE_BITS(SZ_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // site index of one coordinate word under the current register set
  function automatic site_res_t predict_site(input logic [39:0] word);
    int        x [NUM_DIMS];
    int        ls [NUM_DIMS];
    int        gs [NUM_DIMS];
    int        face [NUM_DIMS];
    bit        inbox;
    int        hits;
    int        hd;
    int        od;
    int        d;
    int        k;
    longint    acc;
    logic [63:0] ofs_word;
    logic [31:0] ofs;
    site_res_t res;
    res = '0;
    inbox = 1'b1;
    hits = 0;
    hd = 0;
    for (d = 0; d < NUM_DIMS; d++) begin
      x[d] = int'($signed(word[d*COORD_W +: COORD_W]));
      ls[d] = int'(cfg_reg[CFG_LOCAL_SIZES][(3-d)*SZ_W +: SZ_W]);
      gs[d] = int'(cfg_reg[CFG_GLOBAL_SIZES][(3-d)*SZ_W +: SZ_W]);
      // true periodic wrap; a zero size leaves the coordinate as is
      if (gs[d] > 0) begin
        x[d] = x[d] % gs[d];
        if (x[d] < 0) x[d] += gs[d];
      end
      if (x[d] < 0 || x[d] >= ls[d]) inbox = 1'b0;
      face[d] = 0;
      if (cfg_reg[CFG_PARALLEL_MASK][d]) begin
        if (x[d] == gs[d] - 1) face[d] = -1;
        if (x[d] == ls[d]) face[d] = 1;
      end
      if (face[d] != 0) begin
        hits++;
        hd = d;
      end
    end
    if (inbox) begin
      acc = 0;
      for (d = 0; d < NUM_DIMS; d++) acc = acc * longint'(ls[d]) + longint'(x[d]);
      res.idx = acc[IDX_W-1:0];
      res.found = 1'b1;
    end else if (hits == 1) begin
      // row-major over the three other dims, then halo base
      acc = 0;
      for (k = 0; k < 3; k++) begin
        od = (k < hd) ? k : k + 1;
        acc = acc * longint'(ls[od]) + longint'(x[od]);
      end
      ofs_word = (hd < 2) ? cfg_reg[CFG_OFFSETS_LOW] : cfg_reg[CFG_OFFSETS_HIGH];
      ofs = hd[0] ? ofs_word[63:32] : ofs_word[31:0];
      acc += longint'(cfg_reg[CFG_LOCAL_VOLUME][31:0]) + longint'(ofs);
      if (face[hd] > 0) acc += longint'(cfg_reg[CFG_BORDER_VOLUME][31:1]);
      res.idx = acc[IDX_W-1:0];
      res.found = 1'b1;
    end
    return res;
  endfunction

  // random register set, mostly a consistent box with some extreme dims
  function automatic cfg_set_t random_lattice_cfg();
    int          ls [NUM_DIMS];
    int          gs [NUM_DIMS];
    int          d;
    int          e;
    int          pick;
    logic [3:0]  msk;
    logic [31:0] lpack;
    logic [31:0] gpack;
    logic [31:0] vol;
    logic [31:0] half;
    logic [31:0] face_sz;
    logic [31:0] bvol;
    logic [31:0] ofs [NUM_DIMS];
    cfg_set_t    c;
    msk = 4'($urandom);
    vol = 32'd1;
    for (d = 0; d < NUM_DIMS; d++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) ls[d] = 0;
      else if (pick == 1) ls[d] = 255;
      else if (pick == 2) ls[d] = $urandom_range(0, 255);
      else ls[d] = $urandom_range(1, 6);
      pick = $urandom_range(0, 9);
      if (pick == 0) gs[d] = 0;
      else if (pick == 1) gs[d] = 255;
      else if (pick == 2) gs[d] = $urandom_range(0, 255);
      else gs[d] = ls[d] + $urandom_range(0, 3);
      if (gs[d] > 255) gs[d] = 255;
      lpack[(3-d)*SZ_W +: SZ_W] = SZ_W'(ls[d]);
      gpack[(3-d)*SZ_W +: SZ_W] = SZ_W'(gs[d]);
      vol = vol * 32'(ls[d]);
    end
    // halo layout: backward faces of the split dims, forward faces after half
    half = 32'd0;
    for (d = 0; d < NUM_DIMS; d++) begin
      face_sz = 32'd1;
      for (e = 0; e < NUM_DIMS; e++) if (e != d) face_sz = face_sz * 32'(ls[e]);
      ofs[d] = half;
      if (msk[d]) half += face_sz;
    end
    bvol = half << 1;
    if ($urandom_range(0, 3) == 0) begin
      vol = $urandom;
      bvol = $urandom;
      for (d = 0; d < NUM_DIMS; d++) ofs[d] = $urandom;
    end
    if (vol == 32'd0) vol = 32'd1;
    // upper bits of the narrow registers carry noise
    c[CFG_LOCAL_SIZES]   = {$urandom, lpack};
    c[CFG_GLOBAL_SIZES]  = {$urandom, gpack};
    c[CFG_PARALLEL_MASK] = {$urandom, 28'($urandom), msk};
    c[CFG_LOCAL_VOLUME]  = {$urandom, vol};
    c[CFG_BORDER_VOLUME] = {$urandom, bvol};
    c[CFG_OFFSETS_LOW]   = {ofs[1], ofs[0]};
    c[CFG_OFFSETS_HIGH]  = {ofs[3], ofs[2]};
    return c;
  endfunction

  // coordinate word: mostly one face dim and the rest in the box
  function automatic logic [39:0] random_coords();
    int          ls;
    int          gs;
    int          v;
    int          fd;
    int          d;
    int          pick;
    logic [39:0] w;
    if ($urandom_range(0, 9) < 2) begin
      w[31:0] = $urandom;
      w[39:32] = 8'($urandom);
      return w;
    end
    fd = $urandom_range(0, 4);
    for (d = 0; d < NUM_DIMS; d++) begin
      ls = int'(cfg_reg[CFG_LOCAL_SIZES][(3-d)*SZ_W +: SZ_W]);
      gs = int'(cfg_reg[CFG_GLOBAL_SIZES][(3-d)*SZ_W +: SZ_W]);
      if (d == fd) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) v = -1;
        else if (pick == 1) v = ls;
        else if (pick == 2) v = gs - 1;
        else v = ls + gs * (int'($urandom_range(0, 2)) - 1);
      end else begin
        v = (ls > 0) ? int'($urandom_range(0, ls - 1)) : 0;
        if ($urandom_range(0, 7) == 0) v += gs * (int'($urandom_range(0, 4)) - 2);
      end
      w[d*COORD_W +: COORD_W] = COORD_W'(v);
    end
    return w;
  endfunction

  // single register write, shadowed for the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_reg[idx] = val;
  endtask

  task automatic load_config(input cfg_set_t c);
    write_reg(CFG_LOCAL_SIZES, c[CFG_LOCAL_SIZES]);
    write_reg(CFG_GLOBAL_SIZES, c[CFG_GLOBAL_SIZES]);
    write_reg(CFG_PARALLEL_MASK, c[CFG_PARALLEL_MASK]);
    write_reg(CFG_LOCAL_VOLUME, c[CFG_LOCAL_VOLUME]);
    write_reg(CFG_BORDER_VOLUME, c[CFG_BORDER_VOLUME]);
    write_reg(CFG_OFFSETS_LOW, c[CFG_OFFSETS_LOW]);
    write_reg(CFG_OFFSETS_HIGH, c[CFG_OFFSETS_HIGH]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic settle_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_sites.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one coordinate transfer; the expectation is queued on acceptance
  task automatic send_coord(input logic [39:0] word, input bit chk, input site_res_t typed);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_sites.push_back(chk ? typed : predict_site(word));
  endtask

  // output side backpressure
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    site_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      rx_stall <= rx_burst ? 0 : $urandom_range(0, 3);
      if (pending_sites.size() == 0) begin
        $error("unexpected result: site_index %0h found %0b", m_tdata[IDX_W-1:0], m_tuser);
        mismatch_count++;
      end else begin
        want = pending_sites.pop_front();
        if (m_tdata[IDX_W-1:0] !== want.idx) begin
          $error("site_index: expected %0h, got %0h", want.idx, m_tdata[IDX_W-1:0]);
          mismatch_count++;
        end
        if (m_tuser !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[39:IDX_W] !== '0) begin
          $error("tdata fill: expected 0, got %0h", m_tdata[39:IDX_W]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int          r;
    int          p;
    int          i;
    int          cur;
    logic [39:0] word;
    site_res_t   typed;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOCAL_SIZES;
    cfg_data = '0;
    rst = 1'b1;
    cfg_reg = dir_cfg[0];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    cur = 0;
    for (r = 0; r < DIR_N; r++) begin
      if (dir_tbl[r].phase != cur) begin
        settle_idle();
        cur = dir_tbl[r].phase;
        load_config(dir_cfg[cur]);
      end
      word = {COORD_W'(dir_tbl[r].c3), COORD_W'(dir_tbl[r].c2),
              COORD_W'(dir_tbl[r].c1), COORD_W'(dir_tbl[r].c0)};
      typed.idx = dir_tbl[r].idx;
      typed.found = dir_tbl[r].found;
      send_coord(word, dir_tbl[r].chk, typed);
    end

    // random phases, fresh register set each
    for (p = 0; p < RAND_PHASES; p++) begin
      settle_idle();
      load_config(random_lattice_cfg());
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) send_coord(random_coords(), 1'b0, '0);
    end

    settle_idle();
    if (mismatch_count == 0 && pending_sites.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
